// ----- hdl/arfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arfd_pkg - shared types and constants of the animation RLE frame decoder
// Parse phase codes, depth codes, result kinds, stream constants and the
// result item type passed from the parser to the output register.
// ----------------------------------------------------------------------------
package arfd_pkg;

  // Parse phases
  localparam logic [3:0] PH_SIZE  = 4'd0;
  localparam logic [3:0] PH_FLAGS = 4'd1;
  localparam logic [3:0] PH_START = 4'd2;
  localparam logic [3:0] PH_PAD   = 4'd3;
  localparam logic [3:0] PH_SKIP  = 4'd4;
  localparam logic [3:0] PH_CODE  = 4'd5;
  localparam logic [3:0] PH_PIXEL = 4'd6;
  localparam logic [3:0] PH_DONE  = 4'd7;

  // Depth codes
  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;
  localparam logic [1:0] DEPTH_24 = 2'd2;
  localparam logic [1:0] DEPTH_32 = 2'd3;

  // Result kinds
  localparam logic RK_SPAN = 1'b0;
  localparam logic RK_EOF  = 1'b1;

  // Stream constants
  localparam logic [15:0] HDR_START_LINE_FLAG = 16'h0008;
  localparam logic [3:0]  SIZE_BYTES          = 4'd4;
  localparam logic [3:0]  FLAG_BYTES          = 4'd2;
  localparam logic [3:0]  START_BYTES         = 4'd2;
  localparam logic [3:0]  PAD_BYTES           = 4'd6;
  localparam logic [7:0]  CODE_NOP            = 8'h00;
  localparam logic [7:0]  CODE_NEXT_LINE      = 8'hFF;
  localparam logic [7:0]  SKIP_END            = 8'h00;

  // Configuration register indexes
  localparam logic [1:0] REG_DEPTH_CODE = 2'd0;

  typedef struct packed {
    logic        kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] pix;
    logic [7:0]  rep;
  } result_t;

  function automatic logic [2:0] bytes_per_pixel(input logic [1:0] depth);
    logic [2:0] n;
    begin
      unique case (depth)
        DEPTH_8:  n = 3'd4;
        DEPTH_16: n = 3'd2;
        DEPTH_24: n = 3'd3;
        DEPTH_32: n = 3'd4;
        default:  n = 3'd4;
      endcase
      return n;
    end
  endfunction

endpackage
`default_nettype wire

// ----- hdl/animation_rle_frame_decoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// animation_rle_frame_decoder_unit - animation RLE frame chunk decoder
// Parses a run-length coded frame chunk byte by byte and emits pixel spans
// and an end-of-frame marker.
// ----------------------------------------------------------------------------
// The decoder takes one chunk byte per clock cycle, sustained while the
// result side accepts beats. An input beat is held in the input register
// and goes through the parser logic into the result register. The rate is
// set by the parser step, which updates the small parse state once per
// byte. Each byte gives at most one result beat: a pixel span (x, y, raw
// pixel, repeat count) when a pixel completes, or an end-of-frame beat on
// a zero skip byte. Raise frame_start with the first byte of each chunk.
// Write depth_code over the APB port only while idle.
// ----------------------------------------------------------------------------
module animation_rle_frame_decoder_unit
  import arfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input beats
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_start,
  // result beats
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             result_kind,
  output logic [15:0]      x_pos,
  output logic [15:0]      y_pos,
  output logic [31:0]      pixel_value,
  output logic [7:0]       repeat_count,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [1:0] depth_code;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;

  logic       out_free;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    out_data;

  // APB: one register; all byte lanes of word 0 decode to it
  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == REG_DEPTH_CODE) ? {30'd0, depth_code} : {30'd0, depth_code};

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_code <= DEPTH_8;
    end else if (psel && penable && pwrite && pready) begin
      depth_code <= pwdata[1:0];
    end
  end

  // advance the input register whenever it is empty or the result side can take a beat
  assign step     = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= data_byte;
      s1_start <= frame_start;
    end
  end

  arfd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (s1_byte),
    .frame_start(s1_start),
    .depth_code (depth_code),
    .res_valid  (res_valid),
    .res        (res)
  );

  arfd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .load_data(res),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .free     (out_free),
    .data     (out_data)
  );

  assign result_kind  = out_data.kind;
  assign x_pos        = out_data.x;
  assign y_pos        = out_data.y;
  assign pixel_value  = out_data.pix;
  assign repeat_count = out_data.rep;

endmodule
`default_nettype wire

// ----- hdl/arfd_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arfd_parser - frame chunk parser state and per-byte step logic
// Holds the parse state; on each step consumes one byte and may produce
// one result item.
// ----------------------------------------------------------------------------
module arfd_parser
  import arfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire logic       frame_start,
  input  wire logic [1:0] depth_code,
  output logic            res_valid,
  output result_t         res
);

  logic [3:0]  phase;
  logic [3:0]  hdr_cnt;
  logic [15:0] hdr_flags;
  logic [15:0] column;
  logic [15:0] line;
  logic [7:0]  pixels_left;
  logic        is_run;
  logic [31:0] pix_asm;
  logic [1:0]  byte_in_pixel;

  logic [3:0]  phase_next;
  logic [3:0]  hdr_cnt_next;
  logic [15:0] hdr_flags_next;
  logic [15:0] column_next;
  logic [15:0] line_next;
  logic [7:0]  pixels_left_next;
  logic        is_run_next;
  logic [31:0] pix_asm_next;
  logic [1:0]  byte_in_pixel_next;

  // state as seen by this byte: a frame start clears it first
  logic [3:0]  cur_phase;
  logic [3:0]  cur_cnt;
  logic [15:0] cur_flags;
  logic [15:0] cur_col;
  logic [15:0] cur_line;
  logic [7:0]  cur_left;
  logic        cur_run;
  logic [31:0] cur_asm;
  logic [1:0]  cur_bip;

  logic [3:0]  cnt_inc;
  logic [15:0] flags_shift;
  logic [31:0] asm_shift;
  logic [2:0]  bip_inc;
  logic [7:0]  rep;
  logic [15:0] adv;

  always_comb begin
    cur_phase = frame_start ? PH_SIZE : phase;
    cur_cnt   = frame_start ? 4'd0    : hdr_cnt;
    cur_flags = frame_start ? 16'd0   : hdr_flags;
    cur_col   = frame_start ? 16'd0   : column;
    cur_line  = frame_start ? 16'd0   : line;
    cur_left  = frame_start ? 8'd0    : pixels_left;
    cur_run   = frame_start ? 1'b0    : is_run;
    cur_asm   = frame_start ? 32'd0   : pix_asm;
    cur_bip   = frame_start ? 2'd0    : byte_in_pixel;

    cnt_inc     = cur_cnt + 4'd1;
    flags_shift = {cur_flags[7:0], data_byte};
    asm_shift   = {cur_asm[23:0], data_byte};
    bip_inc     = {1'b0, cur_bip} + 3'd1;
    rep         = cur_run ? cur_left : 8'd1;
    adv         = (depth_code == DEPTH_8) ? {6'd0, rep, 2'b00} : {8'd0, rep};

    phase_next         = phase;
    hdr_cnt_next       = hdr_cnt;
    hdr_flags_next     = hdr_flags;
    column_next        = column;
    line_next          = line;
    pixels_left_next   = pixels_left;
    is_run_next        = is_run;
    pix_asm_next       = pix_asm;
    byte_in_pixel_next = byte_in_pixel;
    res_valid          = 1'b0;
    res                = '0;

    if (step) begin
      phase_next         = cur_phase;
      hdr_cnt_next       = cur_cnt;
      hdr_flags_next     = cur_flags;
      column_next        = cur_col;
      line_next          = cur_line;
      pixels_left_next   = cur_left;
      is_run_next        = cur_run;
      pix_asm_next       = cur_asm;
      byte_in_pixel_next = cur_bip;

      unique case (cur_phase)
        PH_SIZE: begin
          hdr_cnt_next = cnt_inc;
          if (cnt_inc >= SIZE_BYTES) begin
            hdr_cnt_next = 4'd0;
            phase_next   = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          hdr_flags_next = flags_shift;
          hdr_cnt_next   = cnt_inc;
          if (cnt_inc >= FLAG_BYTES) begin
            hdr_cnt_next = 4'd0;
            phase_next   = ((flags_shift & HDR_START_LINE_FLAG) != 16'd0) ? PH_START : PH_SKIP;
          end
        end
        PH_START: begin
          line_next    = {cur_line[7:0], data_byte};
          hdr_cnt_next = cnt_inc;
          if (cnt_inc >= START_BYTES) begin
            hdr_cnt_next = 4'd0;
            phase_next   = PH_PAD;
          end
        end
        PH_PAD: begin
          hdr_cnt_next = cnt_inc;
          if (cnt_inc >= PAD_BYTES) begin
            hdr_cnt_next = 4'd0;
            phase_next   = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (data_byte == SKIP_END) begin
            phase_next = PH_DONE;
            res_valid  = 1'b1;
            res.kind   = RK_EOF;
            res.x      = cur_col;
            res.y      = cur_line;
          end else begin
            column_next = cur_col + {8'd0, data_byte} - 16'd1;
            phase_next  = PH_CODE;
          end
        end
        PH_CODE: begin
          if (data_byte == CODE_NOP) begin
            phase_next = PH_SKIP;
          end else if (data_byte == CODE_NEXT_LINE) begin
            column_next = 16'd0;
            line_next   = cur_line + 16'd1;
            phase_next  = PH_SKIP;
          end else begin
            // literal count, or negated run length (0x80 gives 128)
            pixels_left_next   = data_byte[7] ? (~data_byte + 8'd1) : data_byte;
            is_run_next        = data_byte[7];
            pix_asm_next       = 32'd0;
            byte_in_pixel_next = 2'd0;
            phase_next         = PH_PIXEL;
          end
        end
        PH_PIXEL: begin
          if (bip_inc < bytes_per_pixel(depth_code)) begin
            pix_asm_next       = asm_shift;
            byte_in_pixel_next = bip_inc[1:0];
          end else begin
            pix_asm_next       = 32'd0;
            byte_in_pixel_next = 2'd0;
            column_next        = cur_col + adv;
            if (cur_run || cur_left <= 8'd1) begin
              pixels_left_next = 8'd0;
              phase_next       = PH_CODE;
            end else begin
              pixels_left_next = cur_left - 8'd1;
            end
            res_valid = 1'b1;
            res.kind  = RK_SPAN;
            res.x     = cur_col;
            res.y     = cur_line;
            res.pix   = asm_shift;
            res.rep   = rep;
          end
        end
        default: ; // finished, or an unused phase: drop the byte
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE;
      hdr_cnt       <= 4'd0;
      hdr_flags     <= 16'd0;
      column        <= 16'd0;
      line          <= 16'd0;
      pixels_left   <= 8'd0;
      is_run        <= 1'b0;
      pix_asm       <= 32'd0;
      byte_in_pixel <= 2'd0;
    end else begin
      phase         <= phase_next;
      hdr_cnt       <= hdr_cnt_next;
      hdr_flags     <= hdr_flags_next;
      column        <= column_next;
      line          <= line_next;
      pixels_left   <= pixels_left_next;
      is_run        <= is_run_next;
      pix_asm       <= pix_asm_next;
      byte_in_pixel <= byte_in_pixel_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/arfd_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arfd_out_reg - result register of the decoder
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module arfd_out_reg
  import arfd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_data,
  input  wire logic    out_ready,
  output logic         out_valid,
  output logic         free,
  output result_t      data
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/arfd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arfd_checker - port-level checks of the decoder
// Watches the result channel of the top level.
// ----------------------------------------------------------------------------
module arfd_checker
  import arfd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        result_kind,
  input wire logic [15:0] x_pos,
  input wire logic [15:0] y_pos,
  input wire logic [31:0] pixel_value,
  input wire logic [7:0]  repeat_count
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(x_pos)
      && $stable(y_pos) && $stable(pixel_value) && $stable(repeat_count))
    else $error("result beat changed while stalled");

  a_span_rep: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RK_SPAN |-> repeat_count != 8'd0
      && repeat_count <= 8'd128)
    else $error("span repeat count out of range");

  a_eof_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RK_EOF |-> pixel_value == 32'd0 && repeat_count == 8'd0)
    else $error("end-of-frame beat carries pixel data");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind animation_rle_frame_decoder_unit arfd_checker u_arfd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_kind (result_kind),
  .x_pos       (x_pos),
  .y_pos       (y_pos),
  .pixel_value (pixel_value),
  .repeat_count(repeat_count)
);
`default_nettype wire

// ----- dv/tb_animation_rle_frame_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_animation_rle_frame_decoder_unit - self-checking bench for the RLE decoder
// Feeds frame chunks one byte per beat at all four pixel depths: a short
// directed chunk, then well-formed random chunks mixed with cut-off chunks and
// noise. A byte-level software decoder predicts every span and end-of-frame
// beat; the monitor checks each result beat field by field against it.
// ----------------------------------------------------------------------------
module tb_animation_rle_frame_decoder_unit;
  import arfd_pkg::*;

  localparam int          N_PHASES     = 8;
  localparam int          PHASE_ITEMS  = 100;
  localparam int          CUT_PHASE    = 2;       // ends with a partly received pixel
  localparam int          DRAIN_CYCLES = 8;       // covers the input and result registers plus margin
  localparam int          HOLD_AT      = 80;      // byte count that arms the hold-off
  localparam int          HOLD_LEN     = 300;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [1:0]  DEPTH_ADDR   = 2'(4 * REG_DEPTH_CODE);

  typedef struct {
    logic [7:0] data;
    logic       fs;
    int         lead;   // idle cycles before this beat is offered
  } chunk_byte_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input is known from time zero
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        result_kind;
  logic [15:0] x_pos;
  logic [15:0] y_pos;
  logic [31:0] pixel_value;
  logic [7:0]  repeat_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always #1 clk = ~clk;

  animation_rle_frame_decoder_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .pixel_value  (pixel_value),
    .repeat_count (repeat_count),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  chunk_byte_t byte_q[$];       // bytes waiting to be offered
  result_t     decoded_q[$];    // predicted result beats, oldest first
  logic [7:0]  chunk_buf[$];    // scratch for one generated chunk
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int          lead_cnt = 0;
  int          rx_wait = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          cycle_cnt = 0;
  int          bytes_in = 0;
  int          in_stall_cycles = 0;
  int          frames_built = 0;
  int          spans_seen = 0;
  int          eofs_seen = 0;
  int          bad_beats = 0;

  // Decoder mirror: parse state plus the depth last written over APB
  logic [3:0]  ph = PH_SIZE;
  logic [3:0]  hdr_cnt = '0;
  logic [15:0] hdr_flags = '0;
  logic [15:0] col = '0;
  logic [15:0] row = '0;
  logic [7:0]  px_left = '0;
  logic        px_run = 1'b0;
  logic [31:0] px_acc = '0;
  logic [1:0]  px_idx = '0;
  logic [1:0]  cur_depth = DEPTH_8;

  function automatic int pixel_bytes(input logic [1:0] d);
    case (d)
      DEPTH_16: return 2;
      DEPTH_24: return 3;
      default:  return 4;
    endcase
  endfunction

  function automatic void frame_clear();
    ph        = PH_SIZE;
    hdr_cnt   = '0;
    hdr_flags = '0;
    col       = '0;
    row       = '0;
    px_left   = '0;
    px_run    = 1'b0;
    px_acc    = '0;
    px_idx    = '0;
  endfunction

  // Advance the mirror by one chunk byte; return 1 when it yields a beat.
  function automatic bit decode_byte(input logic [7:0] b, input logic fs,
                                     output result_t r);
    int          rep;
    int          adv;
    logic [15:0] x0;
    r = '0;
    if (fs) frame_clear();
    case (ph)
      PH_SIZE: begin
        hdr_cnt++;
        if (hdr_cnt >= SIZE_BYTES) begin
          hdr_cnt = '0;
          ph = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        hdr_flags = {hdr_flags[7:0], b};
        hdr_cnt++;
        if (hdr_cnt >= FLAG_BYTES) begin
          hdr_cnt = '0;
          ph = ((hdr_flags & HDR_START_LINE_FLAG) != 0) ? PH_START : PH_SKIP;
        end
      end
      PH_START: begin
        row = {row[7:0], b};
        hdr_cnt++;
        if (hdr_cnt >= START_BYTES) begin
          hdr_cnt = '0;
          ph = PH_PAD;
        end
      end
      PH_PAD: begin
        hdr_cnt++;
        if (hdr_cnt >= PAD_BYTES) begin
          hdr_cnt = '0;
          ph = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (b == SKIP_END) begin
          ph = PH_DONE;
          r.kind = RK_EOF;
          r.x = col;
          r.y = row;
          return 1'b1;
        end
        col = col + 16'(b) - 16'd1;
        ph = PH_CODE;
      end
      PH_CODE: begin
        if (b == CODE_NOP) begin
          ph = PH_SKIP;
        end else if (b == CODE_NEXT_LINE) begin
          col = '0;
          row = row + 16'd1;
          ph = PH_SKIP;
        end else begin
          // Top bit clear: literal count; set: negative run length.
          px_left = (b < 8'h80) ? b : 8'(256 - int'(b));
          px_run  = (b >= 8'h80);
          px_acc  = '0;
          px_idx  = '0;
          ph = PH_PIXEL;
        end
      end
      PH_PIXEL: begin
        x0 = col;
        px_acc = {px_acc[23:0], b};
        // A depth written mid-pixel takes effect on the next byte.
        if (int'(px_idx) + 1 < pixel_bytes(cur_depth)) begin
          px_idx = px_idx + 2'd1;
          return 1'b0;
        end
        r.pix  = px_acc;
        px_acc = '0;
        px_idx = '0;
        rep = px_run ? int'(px_left) : 1;
        adv = (cur_depth == DEPTH_8) ? 4 * rep : rep;
        col = col + 16'(adv);
        if (px_run || px_left <= 8'd1) begin
          px_left = '0;
          ph = PH_CODE;
        end else begin
          px_left = px_left - 8'd1;
        end
        r.kind = RK_SPAN;
        r.x    = x0;
        r.y    = row;
        r.rep  = 8'(rep);
        return 1'b1;
      end
      default: ;   // finished: ignore until the next frame start
    endcase
    return 1'b0;
  endfunction

  task automatic note_mismatch(input string msg);
    bad_beats++;
    if (bad_beats <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: offer queued bytes, hold each until taken, predict on accept
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t     r;
    chunk_byte_t cb;
    if (rst) begin
      in_valid <= 1'b0;
      lead_cnt <= 0;
    end else begin
      if (in_valid && in_ready) begin
        bytes_in <= bytes_in + 1;
        if (decode_byte(data_byte, frame_start, r)) decoded_q.push_back(r);
      end
      if (in_valid && !in_ready) begin
        // hold the beat and its payload
      end else if (byte_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (lead_cnt < byte_q[0].lead) begin
        lead_cnt <= lead_cnt + 1;
        in_valid <= 1'b0;
      end else begin
        cb = byte_q.pop_front();
        data_byte   <= cb.data;
        frame_start <= cb.fs;
        in_valid    <= 1'b1;
        lead_cnt    <= 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold-off: once, early in a span-heavy stretch, stall the
  // result side until the HOLD_LEN countdown ends so the block backs up into its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && bytes_in >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      if (in_valid && !in_ready) in_stall_cycles <= in_stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: draw a random stall after each beat when idling is on
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    int w;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      w = rx_idle ? int'($urandom_range(0, 9)) : 0;
      rx_wait   <= w;
      out_ready <= (w == 0);
    end else if (rx_wait != 0) begin
      rx_wait   <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {result_kind, x_pos, y_pos, pixel_value, repeat_count};
      if (decoded_q.size() == 0) begin
        note_mismatch($sformatf("unexpected beat kind=%0d x=%0d y=%0d pix=%08h rep=%0d",
                                got.kind, got.x, got.y, got.pix, got.rep));
      end else begin
        want = decoded_q.pop_front();
        if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
            got.pix !== want.pix || got.rep !== want.rep)
          note_mismatch($sformatf(
            "want kind=%0d x=%0d y=%0d pix=%08h rep=%0d, got kind=%0d x=%0d y=%0d pix=%08h rep=%0d",
            want.kind, want.x, want.y, want.pix, want.rep,
            got.kind, got.x, got.y, got.pix, got.rep));
        if (want.kind == RK_EOF) eofs_seen++;
        else spans_seen++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] d, input logic fs);
    chunk_byte_t cb;
    cb.data = d;
    cb.fs   = fs;
    cb.lead = tx_idle ? int'($urandom_range(0, 9)) : 0;
    byte_q.push_back(cb);
  endtask

  // Push the first n bytes of chunk_buf, raising frame_start on the first.
  task automatic queue_chunk(input int n);
    for (int i = 0; i < n; i++) queue_byte(chunk_buf[i], i == 0);
  endtask

  // Build one well-formed chunk: header, optional start line, skip/code groups
  // with random pixel content, then the zero skip that ends the frame.
  task automatic build_frame(input int bpp, input bit big_lit);
    int          n_skip;
    int          n_code;
    int          n;
    int          k;
    int          s;
    int          c;
    logic [15:0] flags;
    chunk_buf.delete();
    repeat (4) chunk_buf.push_back(8'($urandom));
    flags = 16'($urandom);
    if ($urandom_range(0, 1) != 0) flags = flags | HDR_START_LINE_FLAG;
    else flags = flags & ~HDR_START_LINE_FLAG;
    chunk_buf.push_back(flags[15:8]);
    chunk_buf.push_back(flags[7:0]);
    if ((flags & HDR_START_LINE_FLAG) != 0)
      repeat (int'(START_BYTES) + int'(PAD_BYTES)) chunk_buf.push_back(8'($urandom));
    n_skip = $urandom_range(1, 5);
    for (s = 0; s < n_skip; s++) begin
      if ($urandom_range(0, 3) != 0) chunk_buf.push_back(8'($urandom_range(1, 8)));
      else chunk_buf.push_back(8'($urandom_range(1, 255)));
      n_code = $urandom_range(0, 3);
      for (c = 0; c < n_code; c++) begin
        if ((big_lit && s == 0 && c == 0) || $urandom_range(0, 1) != 0) begin
          // literal run: mostly short, now and then long
          k = $urandom_range(0, 99);
          if (big_lit && s == 0 && c == 0) n = 127;
          else if (k < 85) n = $urandom_range(1, 4);
          else if (k < 99) n = $urandom_range(5, 20);
          else n = $urandom_range(100, 127);
          chunk_buf.push_back(8'(n));
          repeat (n * bpp) chunk_buf.push_back(8'($urandom));
        end else begin
          // repeat run: a run of one would collide with the next-line code
          n = $urandom_range(2, 128);
          chunk_buf.push_back(8'(256 - n));
          repeat (bpp) chunk_buf.push_back(8'($urandom));
        end
      end
      chunk_buf.push_back(($urandom_range(0, 1) != 0) ? CODE_NEXT_LINE : CODE_NOP);
    end
    chunk_buf.push_back(SKIP_END);
  endtask

  // Wait until every byte is taken and every predicted beat has arrived,
  // then let any byte that yields no beat clear the pipeline.
  task automatic wait_idle();
    do @(posedge clk); while (byte_q.size() != 0 || in_valid || decoded_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write depth_code, read it back, and move the mirror to the new depth.
  task automatic set_depth(input logic [1:0] d);
    logic [31:0] rd;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DEPTH_ADDR;
    pwdata  <= 32'(d);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cur_depth = d;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[1:0] !== d)
      note_mismatch($sformatf("depth_code readback %0d, wrote %0d", rd[1:0], d));
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  logic [1:0] phase_depth [N_PHASES];
  bit         phase_tx    [N_PHASES];
  bit         phase_rx    [N_PHASES];

  initial begin
    int fed;
    int k;
    int n;
    int bpp;
    bit first;
    phase_depth = '{DEPTH_16, DEPTH_8, DEPTH_32, DEPTH_16,
                    DEPTH_24, DEPTH_8, DEPTH_32, DEPTH_24};
    phase_tx    = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    phase_rx    = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    // Directed chunk at the reset depth (8-bit indexed). No frame_start on the
    // first byte: the parser must take it as the first size byte anyway.
    repeat (4) queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);                       // flags: start line present
    queue_byte(HDR_START_LINE_FLAG[7:0], 1'b0);
    queue_byte(8'hFF, 1'b0);                       // start line 0xFFFF
    queue_byte(8'hFF, 1'b0);
    repeat (3) begin                               // pad bytes
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
    end
    queue_byte(8'h01, 1'b0);                       // skip of one: no column move
    queue_byte(8'h80, 1'b0);                       // longest run, 128 groups
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hA5, 1'b0);
    queue_byte(8'h5A, 1'b0);
    queue_byte(CODE_NEXT_LINE, 1'b0);              // line wraps to zero
    queue_byte(8'hFF, 1'b0);                       // widest skip
    queue_byte(8'h01, 1'b0);                       // one literal group
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h03, 1'b0);
    queue_byte(8'h04, 1'b0);
    queue_byte(CODE_NOP, 1'b0);
    queue_byte(SKIP_END, 1'b0);                    // end of frame
    queue_byte(8'h5A, 1'b0);                       // trailing bytes: dropped
    queue_byte(8'hC3, 1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    for (int p = 0; p < N_PHASES; p++) begin
      tx_idle = phase_tx[p];
      rx_idle <= phase_rx[p];
      set_depth(phase_depth[p]);
      bpp = pixel_bytes(phase_depth[p]);
      @(negedge clk);
      if (p == CUT_PHASE + 1) begin
        // Finish the pixel left open at 32-bit depth under the new depth:
        // three bytes are already in, so this byte completes it at once.
        queue_byte(8'($urandom), 1'b0);
        repeat (bpp) queue_byte(8'($urandom), 1'b0);
        queue_byte(CODE_NOP, 1'b0);
        queue_byte(SKIP_END, 1'b0);
      end
      fed = 0;
      first = 1'b1;
      while (fed < PHASE_ITEMS) begin
        k = $urandom_range(0, 9);
        if (k < 8) begin
          build_frame(bpp, first && p == 0);
          queue_chunk(chunk_buf.size());
          fed += chunk_buf.size();
          frames_built++;
          if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) queue_byte(8'($urandom), 1'b0);
        end else if (k == 8) begin
          // chunk cut short; the next frame_start must recover
          build_frame(bpp, 1'b0);
          n = $urandom_range(1, chunk_buf.size() - 1);
          queue_chunk(n);
          fed += n;
        end else begin
          n = $urandom_range(1, 10);
          repeat (n) queue_byte(8'($urandom), $urandom_range(0, 7) == 0);
          fed += n;
        end
        first = 1'b0;
      end
      if (p == CUT_PHASE) begin
        // Leave a two-group literal open with three of four bytes received.
        queue_byte(8'($urandom), 1'b1);
        repeat (3) queue_byte(8'($urandom), 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h02, 1'b0);
        repeat (3) queue_byte(8'($urandom), 1'b0);
      end
      wait_idle();
    end

    $display("Decoded %0d chunk bytes (%0d random frames) at 8/16/24/32-bit depth",
             bytes_in, frames_built);
    $display("Checked %0d spans and %0d end-of-frame beats; hold-off stalled input %0d cycles",
             spans_seen, eofs_seen, in_stall_cycles);
    if (bad_beats == 0 && decoded_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
